// ===== design/lst_pkg.sv =====
// Shared constants, command and status types of the lazy segment tree block.
package lst_pkg;

   localparam int LEAF_BITS   = 10;
   localparam int LEAVES      = 1 << LEAF_BITS;
   localparam int NODE_BITS   = LEAF_BITS + 1;
   localparam int NODES       = 1 << NODE_BITS;
   localparam int ACTIVE_BITS = LEAF_BITS + 1;
   localparam int VALUE_BITS  = 31;
   localparam int MOD_BITS    = VALUE_BITS + 1;
   localparam int LEVEL_BITS  = $clog2(NODE_BITS);
   localparam int STEP_BITS   = $clog2(VALUE_BITS + 1);

   localparam logic [VALUE_BITS-1:0]  MODULUS_RESET = {VALUE_BITS{1'b1}};
   localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET  = ACTIVE_BITS'(LEAVES);

   // Configuration register indexes.
   typedef enum logic {
      CSR_MODULUS = 1'b0,
      CSR_ACTIVE  = 1'b1
   } csr_index_type;

   // Request kinds.
   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Operand source of the serial reduction unit.
   typedef enum logic [1:0] {
      SRC_VAL  = 2'd0,
      SRC_SUM  = 2'd1,
      SRC_PEND = 2'd2,
      SRC_DBL  = 2'd3
   } mod_src_type;

   // Choice of the tree node that memory accesses address.
   typedef enum logic [1:0] {
      TGT_HOLD  = 2'd0,
      TGT_NODE  = 2'd1,
      TGT_LEFT  = 2'd2,
      TGT_RIGHT = 2'd3
   } tgt_sel_type;

   typedef struct packed {
      logic        clr_write;
      logic        load;
      logic        mod_start;
      mod_src_type mod_src;
      logic        val_take;
      logic        rd;
      tgt_sel_type tgt_sel;
      logic        t_take;
      logic        s_calc;
      logic        p_calc;
      logic        vsel;
      logic        wr_apply;
      logic        wr_sum;
      logic        pv_take;
      logic        wr_pend_zero;
      logic        acc_add;
      logic        go_left;
      logic        go_right;
      logic        go_up;
      logic        respond;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic bad;
      logic is_query;
      logic mod_busy;
      logic covered;
      logic left_ok;
      logic right_ok;
      logic is_root;
      logic came_left;
      logic pv_zero;
      logic out_free;
   } sts_type;

endpackage

// ===== design/lst_datapath.sv =====
// Datapath of the lazy segment tree: node memories, serial reduction unit and result register.
module lst_datapath
   import lst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  logic                   csr_write_enable,
   input  logic                   csr_index,
   input  logic [VALUE_BITS-1:0]  csr_write_data,
   input  logic                   req_type,
   input  logic [LEAF_BITS-1:0]   req_range_low,
   input  logic [LEAF_BITS-1:0]   req_range_high,
   input  logic [VALUE_BITS-1:0]  req_add_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VALUE_BITS-1:0]  rsp_range_sum,
   output logic                   rsp_bad_range
);

   function automatic logic [LEVEL_BITS-1:0] level_of(input logic [NODE_BITS-1:0] n);
      logic [LEVEL_BITS-1:0] d;
      d = '0;
      for (int i = 0; i < NODE_BITS; i++) begin
         if (n[i]) begin
            d = LEVEL_BITS'(i);
         end
      end
      return d;
   endfunction

   logic [VALUE_BITS-1:0]  node_sum_mem [NODES];
   logic [VALUE_BITS-1:0]  node_pend_mem [NODES];

   logic [VALUE_BITS-1:0]  modulus_ff, modulus_in;
   logic [ACTIVE_BITS-1:0] active_ff, active_in;
   logic [NODE_BITS-1:0]   clr_ff, clr_in;
   logic                   query_ff, bad_ff;
   logic [LEAF_BITS-1:0]   l_ff, r_ff;
   logic [VALUE_BITS-1:0]  val_raw_ff, v_ff, pv_ff, t_ff, s_new_ff, p_new_ff, acc_ff;
   logic [NODE_BITS-1:0]   node_ff, tgt_ff;
   logic                   came_left_ff;
   logic [VALUE_BITS-1:0]  rd_sum_ff, rd_pend_ff;
   logic [VALUE_BITS-1:0]  rem_ff, rem_in, bits_ff, bits_in;
   logic [STEP_BITS-1:0]   cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]  rsp_sum_ff;
   logic                   rsp_bad_ff;

   logic [MOD_BITS-1:0]    m_eff;
   logic [ACTIVE_BITS-1:0] limit;
   logic                   bad_now;
   logic [LEVEL_BITS-1:0]  node_span, tgt_span;
   logic [NODE_BITS-1:0]   node_shift;
   logic [LEAF_BITS-1:0]   node_lo, node_hi, node_mid, node_mask;
   logic [VALUE_BITS-1:0]  mod_x, vsel_val;
   logic [MOD_BITS-1:0]    step_x, step_d;
   logic [MOD_BITS:0]      acc_sum, s_sum, p_sum;
   logic [VALUE_BITS-1:0]  acc_mod, s_mod, p_mod;
   logic                   sum_we, pend_we;
   logic [NODE_BITS-1:0]   waddr;
   logic [VALUE_BITS-1:0]  pend_wdata;

   assign m_eff = (modulus_ff == '0) ? MOD_BITS'(1) << VALUE_BITS : {1'b0, modulus_ff};

   // Leaf limit and range check of the incoming request.
   assign limit   = (active_ff > ACTIVE_BITS'(LEAVES)) ? ACTIVE_BITS'(LEAVES) : active_ff;
   assign bad_now = (req_range_low > req_range_high) || ({1'b0, req_range_high} >= limit);

   // Leaf range covered by the current node.
   assign node_span  = LEVEL_BITS'(LEAF_BITS) - level_of(node_ff);
   assign tgt_span   = LEVEL_BITS'(LEAF_BITS) - level_of(tgt_ff);
   assign node_shift = node_ff << node_span;
   assign node_mask  = ~({LEAF_BITS{1'b1}} << node_span);
   assign node_lo    = node_shift[LEAF_BITS-1:0];
   assign node_hi    = node_lo | node_mask;
   assign node_mid   = node_lo | (node_mask >> 1);

   // Modular additions of residues.
   assign acc_sum = {2'b00, acc_ff} + {2'b00, rem_ff};
   assign s_sum   = {2'b00, t_ff} + {2'b00, rem_ff};
   assign vsel_val = cmd.vsel ? pv_ff : v_ff;
   assign p_sum   = {2'b00, rem_ff} + {2'b00, vsel_val};
   assign acc_mod = (acc_sum >= {1'b0, m_eff}) ? VALUE_BITS'(acc_sum - {1'b0, m_eff})
                                               : acc_sum[VALUE_BITS-1:0];
   assign s_mod   = (s_sum >= {1'b0, m_eff}) ? VALUE_BITS'(s_sum - {1'b0, m_eff})
                                             : s_sum[VALUE_BITS-1:0];
   assign p_mod   = (p_sum >= {1'b0, m_eff}) ? VALUE_BITS'(p_sum - {1'b0, m_eff})
                                             : p_sum[VALUE_BITS-1:0];

   // Serial reduction: one bit a cycle, or doubling for a power-of-two length.
   always_comb begin
      case (cmd.mod_src)
         SRC_VAL:  mod_x = val_raw_ff;
         SRC_SUM:  mod_x = rd_sum_ff;
         SRC_PEND: mod_x = rd_pend_ff;
         default:  mod_x = '0;
      endcase
      step_x  = {rem_ff, bits_ff[VALUE_BITS-1]};
      step_d  = step_x - m_eff;
      rem_in  = rem_ff;
      bits_in = bits_ff;
      cnt_in  = cnt_ff;
      if (cmd.mod_start) begin
         if (cmd.mod_src == SRC_DBL) begin
            rem_in  = vsel_val;
            bits_in = '0;
            cnt_in  = STEP_BITS'(tgt_span);
         end else if ({1'b0, mod_x} < m_eff) begin
            rem_in  = mod_x;
            bits_in = '0;
            cnt_in  = '0;
         end else begin
            rem_in  = '0;
            bits_in = mod_x;
            cnt_in  = STEP_BITS'(VALUE_BITS);
         end
      end else if (cnt_ff != '0) begin
         rem_in  = (step_x >= m_eff) ? step_d[VALUE_BITS-1:0] : step_x[VALUE_BITS-1:0];
         bits_in = bits_ff << 1;
         cnt_in  = cnt_ff - STEP_BITS'(1);
      end
   end

   always_comb begin
      modulus_in = modulus_ff;
      active_in  = active_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MODULUS: modulus_in = csr_write_data;
            CSR_ACTIVE:  active_in  = csr_write_data[ACTIVE_BITS-1:0];
            default: ;
         endcase
      end
      clr_in = cmd.clr_write ? clr_ff + NODE_BITS'(1) : clr_ff;
      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= MODULUS_RESET;
         active_ff    <= ACTIVE_RESET;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         active_ff    <= active_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      if (cmd.load) begin
         query_ff   <= req_type;
         bad_ff     <= bad_now;
         l_ff       <= req_range_low;
         r_ff       <= req_range_high;
         val_raw_ff <= req_add_value;
         node_ff    <= NODE_BITS'(1);
         acc_ff     <= '0;
      end else begin
         if (cmd.go_left) begin
            node_ff <= {node_ff[NODE_BITS-2:0], 1'b0};
         end else if (cmd.go_right) begin
            node_ff <= {node_ff[NODE_BITS-2:0], 1'b1};
         end else if (cmd.go_up) begin
            node_ff      <= node_ff >> 1;
            came_left_ff <= ~node_ff[0];
         end
         if (cmd.acc_add) begin
            acc_ff <= acc_mod;
         end
      end
      case (cmd.tgt_sel)
         TGT_NODE:  tgt_ff <= node_ff;
         TGT_LEFT:  tgt_ff <= {node_ff[NODE_BITS-2:0], 1'b0};
         TGT_RIGHT: tgt_ff <= {node_ff[NODE_BITS-2:0], 1'b1};
         default: ;
      endcase
      if (cmd.val_take) begin
         v_ff <= rem_ff;
      end
      if (cmd.pv_take) begin
         pv_ff <= rem_ff;
      end
      if (cmd.t_take) begin
         t_ff <= rem_ff;
      end
      if (cmd.s_calc) begin
         s_new_ff <= s_mod;
      end
      if (cmd.p_calc) begin
         p_new_ff <= p_mod;
      end
      if (cmd.respond) begin
         rsp_sum_ff <= bad_ff ? '0 : acc_ff;
         rsp_bad_ff <= bad_ff;
      end
   end

   // Node memories: one write and one registered read a cycle each.
   assign sum_we     = cmd.clr_write | cmd.wr_apply | cmd.wr_sum;
   assign pend_we    = cmd.clr_write | cmd.wr_apply | cmd.wr_pend_zero;
   assign waddr      = cmd.clr_write ? clr_ff : tgt_ff;
   assign pend_wdata = cmd.wr_apply ? p_new_ff : '0;

   always_ff @(posedge clock) begin
      if (sum_we) begin
         node_sum_mem[waddr] <= cmd.clr_write ? '0 : s_new_ff;
      end
      if (cmd.rd) begin
         rd_sum_ff <= node_sum_mem[tgt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (pend_we) begin
         node_pend_mem[waddr] <= pend_wdata;
      end
      if (cmd.rd) begin
         rd_pend_ff <= node_pend_mem[tgt_ff];
      end
   end

   always_comb begin
      sts.clr_done  = (clr_ff == NODE_BITS'(NODES - 1));
      sts.bad       = bad_ff;
      sts.is_query  = (query_ff == REQ_QUERY);
      sts.mod_busy  = (cnt_ff != '0);
      sts.covered   = (l_ff <= node_lo) && (node_hi <= r_ff);
      sts.left_ok   = (l_ff <= node_mid);
      sts.right_ok  = (r_ff > node_mid);
      sts.is_root   = (node_ff == NODE_BITS'(1));
      sts.came_left = came_left_ff;
      sts.pv_zero   = (pv_ff == '0);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;
   assign rsp_bad_range = rsp_bad_ff;

endmodule

// ===== design/lst_ctrl.sv =====
// Controller of the lazy segment tree: walks the tree and sequences every node operation.
module lst_ctrl
   import lst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  sts_type sts,
   output cmd_type cmd,
   input  logic    req_valid,
   output logic    req_ready
);

   typedef enum logic [29:0] {
      ST_CLEAR  = 30'd1 << 0,
      ST_IDLE   = 30'd1 << 1,
      ST_CHK    = 30'd1 << 2,
      ST_VAL_W  = 30'd1 << 3,
      ST_ENTER  = 30'd1 << 4,
      ST_AA_RD  = 30'd1 << 5,
      ST_AA_M1  = 30'd1 << 6,
      ST_AA_W1  = 30'd1 << 7,
      ST_AA_W2  = 30'd1 << 8,
      ST_AA_W3  = 30'd1 << 9,
      ST_AA_WR  = 30'd1 << 10,
      ST_Q_RD   = 30'd1 << 11,
      ST_Q_M    = 30'd1 << 12,
      ST_Q_W    = 30'd1 << 13,
      ST_PD_RD  = 30'd1 << 14,
      ST_PD_M   = 30'd1 << 15,
      ST_PD_W   = 30'd1 << 16,
      ST_PD_CHK = 30'd1 << 17,
      ST_PD_R   = 30'd1 << 18,
      ST_DESC   = 30'd1 << 19,
      ST_RET    = 30'd1 << 20,
      ST_UP     = 30'd1 << 21,
      ST_PU_LRD = 30'd1 << 22,
      ST_PU_LM  = 30'd1 << 23,
      ST_PU_LW  = 30'd1 << 24,
      ST_PU_RRD = 30'd1 << 25,
      ST_PU_RM  = 30'd1 << 26,
      ST_PU_RW  = 30'd1 << 27,
      ST_PU_WR  = 30'd1 << 28,
      ST_RESP   = 30'd1 << 29
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic      use_pv_ff, use_pv_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      ret_in    = ret_ff;
      use_pv_in = use_pv_ff;
      req_ready = 1'b0;
      cmd.vsel  = use_pv_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (sts.bad) begin
               state_in = sts.is_query ? ST_RESP : ST_IDLE;
            end else if (sts.is_query) begin
               state_in = ST_ENTER;
            end else begin
               cmd.mod_start = 1'b1;
               cmd.mod_src   = SRC_VAL;
               state_in      = ST_VAL_W;
            end
         end
         ST_VAL_W: begin
            if (!sts.mod_busy) begin
               cmd.val_take = 1'b1;
               state_in     = ST_ENTER;
            end
         end
         ST_ENTER: begin
            cmd.tgt_sel = TGT_NODE;
            if (!sts.covered) begin
               state_in = ST_PD_RD;
            end else if (sts.is_query) begin
               state_in = ST_Q_RD;
            end else begin
               use_pv_in = 1'b0;
               ret_in    = ST_RET;
               state_in  = ST_AA_RD;
            end
         end
         ST_AA_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_AA_M1;
         end
         ST_AA_M1: begin
            cmd.mod_start = 1'b1;
            cmd.mod_src   = SRC_SUM;
            state_in      = ST_AA_W1;
         end
         ST_AA_W1: begin
            if (!sts.mod_busy) begin
               cmd.t_take    = 1'b1;
               cmd.mod_start = 1'b1;
               cmd.mod_src   = SRC_DBL;
               state_in      = ST_AA_W2;
            end
         end
         ST_AA_W2: begin
            if (!sts.mod_busy) begin
               cmd.s_calc    = 1'b1;
               cmd.mod_start = 1'b1;
               cmd.mod_src   = SRC_PEND;
               state_in      = ST_AA_W3;
            end
         end
         ST_AA_W3: begin
            if (!sts.mod_busy) begin
               cmd.p_calc = 1'b1;
               state_in   = ST_AA_WR;
            end
         end
         ST_AA_WR: begin
            cmd.wr_apply = 1'b1;
            state_in     = ret_ff;
         end
         ST_Q_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_Q_M;
         end
         ST_Q_M: begin
            cmd.mod_start = 1'b1;
            cmd.mod_src   = SRC_SUM;
            state_in      = ST_Q_W;
         end
         ST_Q_W: begin
            if (!sts.mod_busy) begin
               cmd.acc_add = 1'b1;
               state_in    = ST_RET;
            end
         end
         ST_PD_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_PD_M;
         end
         ST_PD_M: begin
            cmd.mod_start = 1'b1;
            cmd.mod_src   = SRC_PEND;
            state_in      = ST_PD_W;
         end
         ST_PD_W: begin
            if (!sts.mod_busy) begin
               cmd.pv_take      = 1'b1;
               cmd.wr_pend_zero = 1'b1;
               state_in         = ST_PD_CHK;
            end
         end
         ST_PD_CHK: begin
            if (sts.pv_zero) begin
               state_in = ST_DESC;
            end else begin
               cmd.tgt_sel = TGT_LEFT;
               use_pv_in   = 1'b1;
               ret_in      = ST_PD_R;
               state_in    = ST_AA_RD;
            end
         end
         ST_PD_R: begin
            cmd.tgt_sel = TGT_RIGHT;
            ret_in      = ST_DESC;
            state_in    = ST_AA_RD;
         end
         ST_DESC: begin
            if (sts.left_ok) begin
               cmd.go_left = 1'b1;
            end else begin
               cmd.go_right = 1'b1;
            end
            state_in = ST_ENTER;
         end
         ST_RET: begin
            if (sts.is_root) begin
               state_in = sts.is_query ? ST_RESP : ST_IDLE;
            end else begin
               cmd.go_up = 1'b1;
               state_in  = ST_UP;
            end
         end
         ST_UP: begin
            if (sts.came_left && sts.right_ok) begin
               cmd.go_right = 1'b1;
               state_in     = ST_ENTER;
            end else if (!sts.is_query) begin
               cmd.tgt_sel = TGT_LEFT;
               state_in    = ST_PU_LRD;
            end else begin
               state_in = ST_RET;
            end
         end
         ST_PU_LRD: begin
            cmd.rd   = 1'b1;
            state_in = ST_PU_LM;
         end
         ST_PU_LM: begin
            cmd.mod_start = 1'b1;
            cmd.mod_src   = SRC_SUM;
            state_in      = ST_PU_LW;
         end
         ST_PU_LW: begin
            if (!sts.mod_busy) begin
               cmd.t_take  = 1'b1;
               cmd.tgt_sel = TGT_RIGHT;
               state_in    = ST_PU_RRD;
            end
         end
         ST_PU_RRD: begin
            cmd.rd   = 1'b1;
            state_in = ST_PU_RM;
         end
         ST_PU_RM: begin
            cmd.mod_start = 1'b1;
            cmd.mod_src   = SRC_SUM;
            state_in      = ST_PU_RW;
         end
         ST_PU_RW: begin
            if (!sts.mod_busy) begin
               cmd.s_calc  = 1'b1;
               cmd.tgt_sel = TGT_NODE;
               state_in    = ST_PU_WR;
            end
         end
         ST_PU_WR: begin
            cmd.wr_sum = 1'b1;
            state_in   = ST_RET;
         end
         ST_RESP: begin
            if (sts.out_free) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         ret_ff    <= ST_RET;
         use_pv_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         use_pv_ff <= use_pv_in;
      end
   end

endmodule

// ===== design/lazy_segment_tree_mod_range_sum_core.sv =====
// Top level of the lazy segment tree with range add and range sum modulo a modulus.
// Timing: an item walks the tree one node at a time; a node costs less when a query covers it
// than when an add pushes a pending add into both children, and more again for each stored value
// at or above the modulus that the shared serial reduction unit has to reduce bit by bit.
// Throughput: one item at a time; a bad-range item ends without walking the tree.
// Reset: synchronous; afterwards a clearing pass zeroes the node memories,
// during which no item is accepted, while configuration writes are taken as ever.
module lazy_segment_tree_mod_range_sum_core
   import lst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [LEAF_BITS-1:0]  req_range_low,
   input  logic [LEAF_BITS-1:0]  req_range_high,
   input  logic [VALUE_BITS-1:0] req_add_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_range_sum,
   output logic                  rsp_bad_range,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [VALUE_BITS-1:0] csr_write_data
);

   // The controller walks the tree without a stack: the path back to the root is
   // implied by the node index, and the side that was left tells what comes next.
   cmd_type cmd;
   sts_type sts;

   lst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sts       (sts),
      .cmd       (cmd),
      .req_valid (req_valid),
      .req_ready (req_ready)
   );

   // The datapath holds the node sums and pending adds, the configuration and the
   // result register, so that a result may wait while the next item is taken.
   lst_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_type         (req_type),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .req_add_value    (req_add_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_range_sum    (rsp_range_sum),
      .rsp_bad_range    (rsp_bad_range)
   );

endmodule

// ===== design/lst_checker.sv =====
// Port-level assertions of the lazy segment tree, bound to its top level.
module lst_checker
   import lst_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [VALUE_BITS-1:0] rsp_range_sum,
   input logic                  rsp_bad_range
);

   // A flagged range always reports a zero sum.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_range) |-> (rsp_range_sum == '0))
      else $error("bad range item carries a non-zero sum");

   // A waiting result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_range_sum)
                                     && $stable(rsp_bad_range)))
      else $error("result item changed while stalled");

   // One item is worked on at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while another is in progress");

   // No result directly after reset, and no item taken during the clearing pass start.
   a_reset_quiet: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> (!rsp_valid && !req_ready))
      else $error("block active straight after reset");

endmodule

bind lazy_segment_tree_mod_range_sum_core lst_checker u_lst_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_range_sum (rsp_range_sum),
   .rsp_bad_range (rsp_bad_range)
);
